@@ rtl/wrtc_pkg.sv @@
// shared constants and types for the window range tolerance check
package wrtc_pkg;

   localparam int WINDOW_DEPTH_DEFAULT = 32;
   localparam int SAMPLE_BITS_DEFAULT  = 16;

   localparam int THRESHOLD_BITS = 16;
   localparam int LENGTH_BITS    = 6;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = THRESHOLD_BITS;

   localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 16'd500;
   localparam logic [LENGTH_BITS-1:0]    LENGTH_RESET    = 6'd30;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANGE_THRESHOLD = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_LENGTH   = 1'd1;

   typedef struct packed {
      logic wr_hit;
      logic in_window;
      logic advance;
   } cell_ctl_type;

endpackage

@@ rtl/wrtc_cell.sv @@
// one window slot: holds a sample and folds it into the passing min/max token
module wrtc_cell #(
   parameter int SAMPLE_BITS = wrtc_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  wrtc_pkg::cell_ctl_type        ctl,
   input  logic signed [SAMPLE_BITS-1:0] wr_data,
   input  logic                          prev_valid,
   input  logic signed [SAMPLE_BITS-1:0] prev_lo,
   input  logic signed [SAMPLE_BITS-1:0] prev_hi,
   output logic                          next_valid,
   output logic signed [SAMPLE_BITS-1:0] next_lo,
   output logic signed [SAMPLE_BITS-1:0] next_hi
);

   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic                          valid_ff;
   logic signed [SAMPLE_BITS-1:0] lo_ff;
   logic signed [SAMPLE_BITS-1:0] hi_ff;
   logic signed [SAMPLE_BITS-1:0] lo_in;
   logic signed [SAMPLE_BITS-1:0] hi_in;

   always_comb begin
      lo_in = prev_lo;
      hi_in = prev_hi;
      if (ctl.in_window) begin
         if (sample_ff < prev_lo) begin
            lo_in = sample_ff;
         end
         if (sample_ff > prev_hi) begin
            hi_in = sample_ff;
         end
      end
   end

   // sample store slot, no reset: only read once written
   always_ff @(posedge clock) begin
      if (ctl.wr_hit) begin
         sample_ff <= wr_data;
      end
      if (ctl.advance) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.advance) begin
         valid_ff <= prev_valid;
      end
   end

   assign next_valid = valid_ff;
   assign next_lo    = lo_ff;
   assign next_hi    = hi_ff;

endmodule

@@ rtl/window_range_tolerance_check_top.sv @@
// top level of the sliding window min/max range check
// Each accepted reading is stored in the next slot of a circular window (length set by
// window_length, 0 acting as 1 and values above WINDOW_DEPTH acting as WINDOW_DEPTH), then
// a min/max token starting at the reading walks a chain of WINDOW_DEPTH cells, one cell per
// cycle, each cell folding in its stored sample when it lies in the filled part of the
// window. The result (min, max, their difference, and the flag for a difference above
// range_threshold) is loaded into the output register once the token leaves the last cell
// and that register is free, and the next reading is taken only after that load, so no new
// reading is accepted while one is still in the cell chain. A result waiting in
// the output register does not hold off the next reading. Writing window_length empties
// the window; stored samples are kept but no longer count.
module window_range_tolerance_check_top #(
   parameter int WINDOW_DEPTH = wrtc_pkg::WINDOW_DEPTH_DEFAULT,
   parameter int SAMPLE_BITS  = wrtc_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [SAMPLE_BITS-1:0]         req_reading,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_exceeded,
   output logic signed [SAMPLE_BITS-1:0]         rsp_window_min,
   output logic signed [SAMPLE_BITS-1:0]         rsp_window_max,
   output logic [SAMPLE_BITS-1:0]                rsp_window_range,
   input  logic                                  csr_write_en,
   input  logic [wrtc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [wrtc_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int PTR_W = $clog2(WINDOW_DEPTH);
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int CMP_W = (CNT_W > wrtc_pkg::LENGTH_BITS) ? CNT_W : wrtc_pkg::LENGTH_BITS;
   localparam int RNG_W = (SAMPLE_BITS > wrtc_pkg::THRESHOLD_BITS) ?
                          SAMPLE_BITS : wrtc_pkg::THRESHOLD_BITS;

   logic [wrtc_pkg::THRESHOLD_BITS-1:0] threshold_ff;
   logic [wrtc_pkg::LENGTH_BITS-1:0]    length_ff;
   logic [PTR_W-1:0]                    wp_ff;
   logic [PTR_W-1:0]                    wp_in;
   logic [CNT_W-1:0]                    fc_ff;
   logic [CNT_W-1:0]                    fc_in;
   logic                                busy_ff;
   logic                                launch_valid_ff;
   logic signed [SAMPLE_BITS-1:0]       launch_sample_ff;
   logic                                rsp_valid_ff;
   logic                                exceeded_ff;
   logic signed [SAMPLE_BITS-1:0]       min_ff;
   logic signed [SAMPLE_BITS-1:0]       max_ff;
   logic [SAMPLE_BITS-1:0]              range_ff;

   logic [CNT_W-1:0]                    len_c;
   logic [PTR_W-1:0]                    wp_cur;
   logic [CNT_W-1:0]                    fc_cur;
   logic [CNT_W-1:0]                    wp_inc;
   logic                                accept;
   logic                                load;
   logic                                advance_c;
   logic [SAMPLE_BITS-1:0]              diff_c;

   wrtc_pkg::cell_ctl_type              cell_ctl [WINDOW_DEPTH];
   logic                                tok_valid [WINDOW_DEPTH+1];
   logic signed [SAMPLE_BITS-1:0]       tok_lo [WINDOW_DEPTH+1];
   logic signed [SAMPLE_BITS-1:0]       tok_hi [WINDOW_DEPTH+1];

   assign accept = req_valid && !req_stall;

   // effective window length
   always_comb begin
      if (length_ff == '0) begin
         len_c = CNT_W'(1);
      end else if (CMP_W'(length_ff) > CMP_W'(WINDOW_DEPTH)) begin
         len_c = CNT_W'(WINDOW_DEPTH);
      end else begin
         len_c = CNT_W'(length_ff);
      end
   end

   always_comb begin
      wp_cur = (CNT_W'(wp_ff) >= len_c) ? '0 : wp_ff;
      fc_cur = (fc_ff > len_c) ? len_c : fc_ff;
      wp_inc = CNT_W'(wp_cur) + CNT_W'(1);
      wp_in  = (wp_inc >= len_c) ? '0 : wp_inc[PTR_W-1:0];
      fc_in  = (fc_cur < len_c) ? fc_cur + CNT_W'(1) : fc_cur;
   end

   // the token leaves the chain only when the output register is free
   assign load      = tok_valid[WINDOW_DEPTH] && (!rsp_valid_ff || !rsp_stall);
   assign advance_c = !(tok_valid[WINDOW_DEPTH] && !load);
   assign diff_c    = tok_hi[WINDOW_DEPTH] - tok_lo[WINDOW_DEPTH];

   assign tok_valid[0] = launch_valid_ff;
   assign tok_lo[0]    = launch_sample_ff;
   assign tok_hi[0]    = launch_sample_ff;

   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      assign cell_ctl[i].wr_hit    = accept && (wp_cur == PTR_W'(i));
      assign cell_ctl[i].in_window = CNT_W'(i) < fc_ff;
      assign cell_ctl[i].advance   = advance_c;

      wrtc_cell #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl[i]),
         .wr_data    (req_reading),
         .prev_valid (tok_valid[i]),
         .prev_lo    (tok_lo[i]),
         .prev_hi    (tok_hi[i]),
         .next_valid (tok_valid[i+1]),
         .next_lo    (tok_lo[i+1]),
         .next_hi    (tok_hi[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= wrtc_pkg::THRESHOLD_RESET;
         length_ff       <= wrtc_pkg::LENGTH_RESET;
         wp_ff           <= '0;
         fc_ff           <= '0;
         busy_ff         <= 1'b0;
         launch_valid_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (accept) begin
            wp_ff           <= wp_in;
            fc_ff           <= fc_in;
            busy_ff         <= 1'b1;
            launch_valid_ff <= 1'b1;
         end else begin
            if (advance_c) begin
               launch_valid_ff <= 1'b0;
            end
            if (load) begin
               busy_ff <= 1'b0;
            end
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_en) begin
            case (csr_index)
               wrtc_pkg::CSR_RANGE_THRESHOLD: begin
                  threshold_ff <= csr_data[wrtc_pkg::THRESHOLD_BITS-1:0];
               end
               wrtc_pkg::CSR_WINDOW_LENGTH: begin
                  length_ff <= csr_data[wrtc_pkg::LENGTH_BITS-1:0];
                  wp_ff     <= '0;
                  fc_ff     <= '0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         launch_sample_ff <= req_reading;
      end
      if (load) begin
         min_ff      <= tok_lo[WINDOW_DEPTH];
         max_ff      <= tok_hi[WINDOW_DEPTH];
         range_ff    <= diff_c;
         exceeded_ff <= RNG_W'(diff_c) > RNG_W'(threshold_ff);
      end
   end

   assign req_stall        = busy_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_exceeded     = exceeded_ff;
   assign rsp_window_min   = min_ff;
   assign rsp_window_max   = max_ff;
   assign rsp_window_range = range_ff;

endmodule

@@ rtl/wrtc_checker.sv @@
// port-level checks for the window range tolerance check, bound to the top level
module wrtc_checker #(
   parameter int SAMPLE_BITS = wrtc_pkg::SAMPLE_BITS_DEFAULT
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [SAMPLE_BITS-1:0] rsp_window_min,
   input logic [SAMPLE_BITS-1:0] rsp_window_max,
   input logic [SAMPLE_BITS-1:0] rsp_window_range
);

   // one item in the scan at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted while scan busy");

   // a result never shows up right after an item is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !$rose(rsp_valid))
      else $error("result too early");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_window_min) <= $signed(rsp_window_max)))
      else $error("window min above max");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_window_range == rsp_window_max - rsp_window_min))
      else $error("window range mismatch");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled item dropped");

endmodule

bind window_range_tolerance_check_top wrtc_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_wrtc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_window_min   (rsp_window_min),
   .rsp_window_max   (rsp_window_max),
   .rsp_window_range (rsp_window_range)
);

@@ tb/window_range_tolerance_check_checker.sv @@
// window range check scoreboard: tracks the window, predicts each result and compares
`timescale 1ns / 100ps
module window_range_tolerance_check_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic signed [wrtc_pkg::SAMPLE_BITS_DEFAULT-1:0] req_reading,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic                                  rsp_exceeded,
   input  logic signed [wrtc_pkg::SAMPLE_BITS_DEFAULT-1:0] rsp_window_min,
   input  logic signed [wrtc_pkg::SAMPLE_BITS_DEFAULT-1:0] rsp_window_max,
   input  logic [wrtc_pkg::SAMPLE_BITS_DEFAULT-1:0]        rsp_window_range,
   input  logic                                  csr_write_en,
   input  logic [wrtc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [wrtc_pkg::CSR_DATA_BITS-1:0]    csr_data,
   output int                                    fail_count,
   output int                                    outstanding
);

   localparam int DEPTH    = wrtc_pkg::WINDOW_DEPTH_DEFAULT;
   localparam int SB       = wrtc_pkg::SAMPLE_BITS_DEFAULT;
   localparam int LEN_BITS = wrtc_pkg::LENGTH_BITS;
   localparam int THR_BITS = wrtc_pkg::THRESHOLD_BITS;

   typedef struct {
      logic                 exceeded;
      logic signed [SB-1:0] lo;
      logic signed [SB-1:0] hi;
      logic [SB-1:0]        span;
   } window_result_type;

   logic signed [SB-1:0]      sample_slots [DEPTH];
   logic [4:0]                next_slot;
   logic [LEN_BITS-1:0]       valid_count;
   logic [THR_BITS-1:0]       alarm_threshold;
   logic [LEN_BITS-1:0]       length_setting;
   window_result_type         expected_windows [$];
   int                        mismatches = 0;
   int                        waiting = 0;

   assign fail_count  = mismatches;
   assign outstanding = waiting;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [SB-1:0] got,
                              input logic [SB-1:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %h, want %h", name, got, want));
      end
   endtask

   // store the reading, then fold min/max over the filled slots 0..count-1
   function automatic window_result_type absorb_reading(input logic signed [SB-1:0] reading);
      window_result_type r;
      int len;
      int slot;
      int count;
      int lo;
      int hi;
      int span;
      if (length_setting == 0) len = 1;
      else if (length_setting > DEPTH) len = DEPTH;
      else len = length_setting;
      slot  = next_slot;
      count = valid_count;
      if (slot >= len) slot = 0;
      if (count > len) count = len;
      sample_slots[slot] = reading;
      slot++;
      if (slot >= len) slot = 0;
      if (count < len) count++;
      next_slot   = 5'(slot);
      valid_count = LEN_BITS'(count);
      lo = reading;
      hi = reading;
      for (int i = 0; i < count; i++) begin
         if (sample_slots[i] < lo) lo = sample_slots[i];
         if (sample_slots[i] > hi) hi = sample_slots[i];
      end
      span = hi - lo;
      r.exceeded = span > int'(alarm_threshold);
      r.lo       = SB'(lo);
      r.hi       = SB'(hi);
      r.span     = SB'(span);
      return r;
   endfunction

   always @(posedge clock) begin
      window_result_type want;
      if (reset) begin
         next_slot       = '0;
         valid_count     = '0;
         alarm_threshold = wrtc_pkg::THRESHOLD_RESET;
         length_setting  = wrtc_pkg::LENGTH_RESET;
         expected_windows.delete();
      end else begin
         // results leave before this edge's item is added
         if (rsp_valid && !rsp_stall) begin
            if (expected_windows.size() == 0) begin
               report_mismatch($sformatf("unexpected result min %h max %h range %h",
                                         rsp_window_min, rsp_window_max, rsp_window_range));
            end else begin
               want = expected_windows.pop_front();
               check_field("exceeded", rsp_exceeded, want.exceeded);
               check_field("window_min", rsp_window_min, want.lo);
               check_field("window_max", rsp_window_max, want.hi);
               check_field("window_range", rsp_window_range, want.span);
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               wrtc_pkg::CSR_RANGE_THRESHOLD: begin
                  alarm_threshold = csr_data[THR_BITS-1:0];
               end
               wrtc_pkg::CSR_WINDOW_LENGTH: begin
                  // a new length empties the window
                  length_setting = csr_data[LEN_BITS-1:0];
                  next_slot      = '0;
                  valid_count    = '0;
               end
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_windows.push_back(absorb_reading(req_reading));
         end
      end
      waiting = expected_windows.size();
   end

endmodule

@@ tb/window_range_tolerance_check_top_tb.sv @@
// testbench top for the window range check: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module window_range_tolerance_check_top_tb;

   localparam int DEPTH       = wrtc_pkg::WINDOW_DEPTH_DEFAULT;
   localparam int SB          = wrtc_pkg::SAMPLE_BITS_DEFAULT;
   localparam int IDX_W       = wrtc_pkg::CSR_INDEX_BITS;
   localparam int CSR_W       = wrtc_pkg::CSR_DATA_BITS;
   localparam int LEN_BITS    = wrtc_pkg::LENGTH_BITS;
   localparam int ITEM_TARGET = 900;
   localparam int LONG_HOLD   = 400;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [SB-1:0]      req_reading;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic                      rsp_exceeded;
   logic signed [SB-1:0]      rsp_window_min;
   logic signed [SB-1:0]      rsp_window_max;
   logic [SB-1:0]             rsp_window_range;
   logic                      csr_write_en;
   logic [IDX_W-1:0]          csr_index;
   logic [CSR_W-1:0]          csr_data;
   int                        fail_count;
   int                        outstanding;
   logic                      quiet_mode = 1'b0;
   int                        hold_requests = 0;

   always #5 clock = ~clock;

   window_range_tolerance_check_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_reading      (req_reading),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_exceeded     (rsp_exceeded),
      .rsp_window_min   (rsp_window_min),
      .rsp_window_max   (rsp_window_max),
      .rsp_window_range (rsp_window_range),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   window_range_tolerance_check_checker watch (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_reading      (req_reading),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_exceeded     (rsp_exceeded),
      .rsp_window_min   (rsp_window_min),
      .rsp_window_max   (rsp_window_max),
      .rsp_window_range (rsp_window_range),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   // result side: random stalls, or a long hold whenever one is requested
   initial begin
      int holds_done;
      holds_done = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_done) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD - 1) @(negedge clock);
            holds_done++;
         end else begin
            rsp_stall <= !quiet_mode && ($urandom_range(0, 99) < 25);
         end
      end
   end

   task automatic write_reg(input logic [IDX_W-1:0] index, input int value);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_data     <= CSR_W'(value);
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic offer_reading(input logic signed [SB-1:0] value);
      int gap;
      if (!quiet_mode && $urandom_range(0, 99) < 25) begin
         // mostly short gaps, sometimes one longer than a whole item
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_reading <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (DEPTH + 2) @(negedge clock);
   endtask

   initial begin
      int random_sent;
      int phase;
      int phase_items;
      int style;
      int base;
      int spread;
      int v;
      logic signed [SB-1:0] value;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_reading  = '0;
      csr_write_en = 1'b0;
      csr_index    = wrtc_pkg::CSR_RANGE_THRESHOLD;
      csr_data     = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings, full-scale swing
      offer_reading(16'sd0);
      offer_reading(16'sd32767);
      offer_reading(-16'sd32768);
      offer_reading(-16'sd1);
      offer_reading(16'sd1);
      drain_results();

      // two-slot window, range landing on and just past the threshold
      write_reg(wrtc_pkg::CSR_WINDOW_LENGTH, 2);
      offer_reading(16'sd100);
      offer_reading(16'sd600);
      offer_reading(16'sd601);
      offer_reading(16'sd100);
      drain_results();

      // zero length acts as one, zero threshold
      write_reg(wrtc_pkg::CSR_RANGE_THRESHOLD, 0);
      write_reg(wrtc_pkg::CSR_WINDOW_LENGTH, 0);
      offer_reading(16'sd5);
      offer_reading(-16'sd5);
      offer_reading(16'sd32767);
      drain_results();

      // pressure-style threshold
      write_reg(wrtc_pkg::CSR_RANGE_THRESHOLD, 200);
      write_reg(wrtc_pkg::CSR_WINDOW_LENGTH, 3);
      offer_reading(16'sd0);
      offer_reading(16'sd200);
      offer_reading(16'sd201);
      drain_results();

      // length above depth, threshold at its top
      write_reg(wrtc_pkg::CSR_RANGE_THRESHOLD, 65535);
      write_reg(wrtc_pkg::CSR_WINDOW_LENGTH, 63);
      offer_reading(16'sd32767);
      offer_reading(-16'sd32768);
      offer_reading(16'sh5555);
      offer_reading(-16'sd21846);
      drain_results();

      random_sent = 0;
      phase = 0;
      while (random_sent < ITEM_TARGET) begin
         style = $urandom_range(0, 3);
         if (style != 1) begin
            case ($urandom_range(0, 5))
               0: v = 0;
               1: v = 65535;
               2: v = 500;
               3: v = 200;
               4: v = $urandom_range(0, 65535);
               default: v = $urandom_range(0, 1200);
            endcase
            write_reg(wrtc_pkg::CSR_RANGE_THRESHOLD, v);
         end
         if (style != 0) begin
            case ($urandom_range(0, 7))
               0: v = 0;
               1: v = 1;
               2: v = 32;
               3: v = $urandom_range(33, 63);
               4: v = 30;
               5: v = $urandom_range(1, 8);
               default: v = $urandom_range(2, 31);
            endcase
            // upper data bits are junk for the length register
            write_reg(wrtc_pkg::CSR_WINDOW_LENGTH, v | ($urandom_range(0, 1023) << LEN_BITS));
         end
         quiet_mode <= (phase == 4);
         if (phase % 5 == 2) hold_requests <= hold_requests + 1;
         phase_items = $urandom_range(10, 80);
         style  = $urandom_range(0, 3);
         base   = int'($urandom_range(0, 65535)) - 32768;
         spread = (style == 1) ? $urandom_range(0, 600) : $urandom_range(0, 40000);
         for (int n = 0; n < phase_items; n++) begin
            case (style)
               0: value = SB'($urandom);
               1, 2: begin
                  // readings wandering around a baseline
                  v = base + int'($urandom_range(0, 2 * spread)) - spread;
                  if (v > 32767) v = 32767;
                  if (v < -32768) v = -32768;
                  value = SB'(v);
               end
               default: begin
                  case ($urandom_range(0, 4))
                     0: value = 16'sd32767;
                     1: value = -16'sd32768;
                     2: value = 16'sd0;
                     3: value = -16'sd1;
                     default: value = SB'($urandom);
                  endcase
               end
            endcase
            offer_reading(value);
            random_sent++;
         end
         drain_results();
         phase++;
      end

      if (fail_count == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/wrtc_pkg.sv
rtl/wrtc_cell.sv
rtl/window_range_tolerance_check_top.sv
rtl/wrtc_checker.sv
tb/window_range_tolerance_check_checker.sv
tb/window_range_tolerance_check_top_tb.sv
